### hdl/ppsc_pkg.sv
package ppsc_pkg;

  // Parking sequence phases
  typedef enum logic [3:0] {
    PH_INITIAL  = 4'd0,
    PH_SEARCH   = 4'd1,
    PH_MEASURE  = 4'd2,
    PH_POSITION = 4'd3,
    PH_REVERSE  = 4'd4,
    PH_BACK     = 4'd5,
    PH_FRONT    = 4'd6,
    PH_FINISH   = 4'd7,
    PH_STOP     = 4'd8
  } phase_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_MIN_GAP           = 3'd0,
    REG_REVERSE_LENGTH    = 3'd1,
    REG_STRAIGHTEN_LENGTH = 3'd2,
    REG_BRAKE_BUFFER      = 3'd3,
    REG_PARK_MARGIN       = 3'd4,
    REG_SPEED_FORWARD     = 3'd5,
    REG_SPEED_REVERSE     = 3'd6,
    REG_STOP_TICKS        = 3'd7
  } reg_idx_t;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned RANGE_W    = 16;
  localparam int unsigned SPEED_W    = 8;
  localparam int unsigned STEER_W    = 10;
  localparam int unsigned PHASE_W    = 4;
  localparam int unsigned COUNT_W    = 6;
  localparam int unsigned OUT_DATA_W = 24;

  // Steering angles in hundredths
  localparam logic signed [STEER_W-1:0] STEER_NEUTRAL    = 10'sd0;
  localparam logic signed [STEER_W-1:0] STEER_POSITION   = -10'sd30;
  localparam logic signed [STEER_W-1:0] STEER_REVERSE    = 10'sd400;
  localparam logic signed [STEER_W-1:0] STEER_BACK_ENTRY = -10'sd500;
  localparam logic signed [STEER_W-1:0] STEER_BACK_DRIVE = -10'sd300;

  localparam logic signed [SPEED_W-1:0] SPEED_ZERO = 8'sd0;
  localparam logic [COUNT_W-1:0]        BRAKE_MAX  = 6'd63;

  typedef struct packed {
    logic        [15:0] min_gap;
    logic        [15:0] reverse_length;
    logic        [15:0] straighten_length;
    logic        [14:0] brake_buffer;
    logic        [14:0] park_margin;
    logic signed [7:0]  speed_forward;
    logic signed [7:0]  speed_reverse;
    logic        [5:0]  stop_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    min_gap:           16'd650,
    reverse_length:    16'd600,
    straighten_length: 16'd500,
    brake_buffer:      15'd220,
    park_margin:       15'd300,
    speed_forward:     8'sd2,
    speed_reverse:     8'sd1,
    stop_ticks:        6'd20
  };

  // Sequencer state apart from the path mark
  typedef struct packed {
    phase_t                     phase;
    logic signed [RANGE_W-1:0]  prev_side;
    logic        [COUNT_W-1:0]  brake_count;
    logic signed [SPEED_W-1:0]  speed;
    logic signed [STEER_W-1:0]  steer;
  } ctl_state_t;

  localparam ctl_state_t STATE_RESET = '{
    phase:       PH_INITIAL,
    prev_side:   16'sd0,
    brake_count: 6'd0,
    speed:       8'sd0,
    steer:       10'sd0
  };

endpackage

### hdl/ppsc_step.sv
module ppsc_step #(
  parameter int unsigned PATH_WIDTH = 32
) (
  input  ppsc_pkg::cfg_t                            cfg,
  input  ppsc_pkg::ctl_state_t                      state_cur,
  input  logic [PATH_WIDTH-1:0]                     start_path_cur,
  input  logic [PATH_WIDTH-1:0]                     path,
  input  logic signed [ppsc_pkg::RANGE_W-1:0]       side,
  input  logic signed [ppsc_pkg::RANGE_W-1:0]       rear,
  input  logic signed [ppsc_pkg::RANGE_W-1:0]       front,
  output ppsc_pkg::ctl_state_t                      state_nxt,
  output logic [PATH_WIDTH-1:0]                     start_path_nxt,
  output logic                                      parked
);

  logic [PATH_WIDTH-1:0]             path_delta;
  logic [ppsc_pkg::COUNT_W-1:0]      bc_inc;
  logic [ppsc_pkg::COUNT_W-1:0]      bc_wait;
  logic                              wait_done;
  logic                              side_seen;
  logic                              side_clear;
  logic                              rear_brake;
  logic                              front_brake;
  logic                              rear_finish;
  logic                              front_finish;

  // Path since the last mark, wrapping
  assign path_delta = path - start_path_cur;

  // Brake wait counter, saturating, cleared when the wait completes
  assign bc_inc    = (state_cur.brake_count == ppsc_pkg::BRAKE_MAX) ? ppsc_pkg::BRAKE_MAX
                   : state_cur.brake_count + ppsc_pkg::COUNT_W'(1);
  assign wait_done = bc_inc > cfg.stop_ticks;
  assign bc_wait   = wait_done ? '0 : bc_inc;

  // Object seen on two ticks in a row, or missing on two ticks in a row
  assign side_seen  = (side > 0) && (state_cur.prev_side > 0);
  assign side_clear = side[ppsc_pkg::RANGE_W-1] && state_cur.prev_side[ppsc_pkg::RANGE_W-1];

  // Range windows; the sign bit rules out "nothing seen"
  assign rear_brake   = !rear[ppsc_pkg::RANGE_W-1] && (rear[14:0] <= cfg.brake_buffer);
  assign front_brake  = !front[ppsc_pkg::RANGE_W-1] && (front[14:0] <= cfg.brake_buffer);
  assign rear_finish  = !rear[ppsc_pkg::RANGE_W-1] && (rear[14:0] != 15'd0)
                      && (rear[14:0] <= cfg.park_margin);
  assign front_finish = !front[ppsc_pkg::RANGE_W-1] && (front[14:0] != 15'd0)
                      && (front[14:0] <= cfg.park_margin);

  // Step the sequence by one tick
  always_comb begin
    state_nxt           = state_cur;
    state_nxt.prev_side = side;
    start_path_nxt      = start_path_cur;
    parked              = 1'b0;
    unique case (state_cur.phase)
      ppsc_pkg::PH_INITIAL: begin
        state_nxt.speed = cfg.speed_forward;
        state_nxt.steer = ppsc_pkg::STEER_NEUTRAL;
        if (side_seen) begin
          state_nxt.phase = ppsc_pkg::PH_SEARCH;
        end
      end
      ppsc_pkg::PH_SEARCH: begin
        state_nxt.speed = cfg.speed_forward;
        if (side_clear) begin
          start_path_nxt  = path;
          state_nxt.phase = ppsc_pkg::PH_MEASURE;
        end
      end
      ppsc_pkg::PH_MEASURE: begin
        if (side_seen) begin
          if (path_delta > PATH_WIDTH'(cfg.min_gap)) begin
            state_nxt.speed = ppsc_pkg::SPEED_ZERO;
            state_nxt.steer = ppsc_pkg::STEER_POSITION;
            state_nxt.phase = ppsc_pkg::PH_POSITION;
          end else begin
            state_nxt.phase = ppsc_pkg::PH_SEARCH;
          end
        end
      end
      ppsc_pkg::PH_POSITION: begin
        state_nxt.brake_count = bc_wait;
        if (wait_done) begin
          state_nxt.speed = cfg.speed_reverse;
          state_nxt.steer = ppsc_pkg::STEER_REVERSE;
          start_path_nxt  = path;
          state_nxt.phase = ppsc_pkg::PH_REVERSE;
        end
      end
      ppsc_pkg::PH_REVERSE: begin
        if (path_delta > PATH_WIDTH'(cfg.reverse_length)) begin
          state_nxt.steer = ppsc_pkg::STEER_BACK_ENTRY;
          start_path_nxt  = path;
          state_nxt.phase = ppsc_pkg::PH_BACK;
        end
      end
      ppsc_pkg::PH_BACK: begin
        state_nxt.speed = cfg.speed_reverse;
        state_nxt.steer = ppsc_pkg::STEER_BACK_DRIVE;
        if (path_delta > PATH_WIDTH'(cfg.straighten_length)) begin
          state_nxt.speed = ppsc_pkg::SPEED_ZERO;
          state_nxt.steer = ppsc_pkg::STEER_NEUTRAL;
          state_nxt.phase = ppsc_pkg::PH_FRONT;
        end else if (rear_brake) begin
          state_nxt.speed       = ppsc_pkg::SPEED_ZERO;
          state_nxt.brake_count = bc_wait;
          if (wait_done) begin
            state_nxt.phase = ppsc_pkg::PH_FRONT;
          end
        end
      end
      ppsc_pkg::PH_FRONT: begin
        if (front_brake) begin
          state_nxt.speed       = ppsc_pkg::SPEED_ZERO;
          state_nxt.brake_count = bc_wait;
          if (wait_done) begin
            state_nxt.phase = ppsc_pkg::PH_FINISH;
          end
        end
      end
      ppsc_pkg::PH_FINISH: begin
        if (rear_finish) begin
          state_nxt.speed = cfg.speed_forward;
        end else if (front_finish) begin
          state_nxt.speed = cfg.speed_reverse;
        end else begin
          state_nxt.speed = ppsc_pkg::SPEED_ZERO;
          state_nxt.phase = ppsc_pkg::PH_STOP;
        end
      end
      ppsc_pkg::PH_STOP: begin
        state_nxt.speed       = ppsc_pkg::SPEED_ZERO;
        state_nxt.brake_count = bc_wait;
        parked                = wait_done;
      end
      default: begin
        // Unused codes only hold the outputs
        state_nxt.phase = state_cur.phase;
      end
    endcase
  end

endmodule

### hdl/parallel_parking_sequencer_core.sv
// Channel | Direction | Handshake            | Payload
// in_     | slave     | in_tvalid/in_tready  | in_tdata: path, side, rear, front ranges
// out_    | master    | out_tvalid/out_tready| out_tdata: speed, steer, phase; out_tuser: parked
// cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One tick per clock cycle unless the result side stalls; each request is taken
// into the input register and its result into the result register, which presents it,
// with one step of sequencer logic between the two registers. Reset is
// synchronous: it clears the phase and held commands and loads the default
// register values. While out_tready is low the result holds and one more
// request waits in the input register; after that in_tready drops. The
// register port never stalls.
module parallel_parking_sequencer_core #(
  parameter int unsigned PATH_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata, lowest bit up: path_travelled, side_range, rear_range, front_range
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((PATH_WIDTH+48+7)/8)*8-1:0]   in_tdata,
  // out_tdata, lowest bit up: speed_cmd, steer_cmd, phase
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [ppsc_pkg::OUT_DATA_W-1:0]      out_tdata,
  // out_tuser: parked
  output logic                                 out_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [2:0]                           cfg_index,
  input  logic [ppsc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int unsigned RW = ppsc_pkg::RANGE_W;

  ppsc_pkg::cfg_t                 cfg_r;
  ppsc_pkg::ctl_state_t           state_r;
  ppsc_pkg::ctl_state_t           state_nxt;
  logic [PATH_WIDTH-1:0]          start_path_r;
  logic [PATH_WIDTH-1:0]          start_path_nxt;
  logic                           parked_nxt;

  logic                           s1_valid_r;
  logic [PATH_WIDTH-1:0]          s1_path_r;
  logic signed [RW-1:0]           s1_side_r;
  logic signed [RW-1:0]           s1_rear_r;
  logic signed [RW-1:0]           s1_front_r;

  logic                           out_valid_r;
  ppsc_pkg::ctl_state_t           out_state_r;
  logic                           out_parked_r;

  logic                           in_fire;
  logic                           out_free;
  logic                           s1_fire;

  // Handshake
  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= ppsc_pkg::CFG_RESET;
    end else if (cfg_valid) begin
      unique case (ppsc_pkg::reg_idx_t'(cfg_index))
        ppsc_pkg::REG_MIN_GAP:           cfg_r.min_gap           <= cfg_data;
        ppsc_pkg::REG_REVERSE_LENGTH:    cfg_r.reverse_length    <= cfg_data;
        ppsc_pkg::REG_STRAIGHTEN_LENGTH: cfg_r.straighten_length <= cfg_data;
        ppsc_pkg::REG_BRAKE_BUFFER:      cfg_r.brake_buffer      <= cfg_data[14:0];
        ppsc_pkg::REG_PARK_MARGIN:       cfg_r.park_margin       <= cfg_data[14:0];
        ppsc_pkg::REG_SPEED_FORWARD:     cfg_r.speed_forward     <= $signed(cfg_data[7:0]);
        ppsc_pkg::REG_SPEED_REVERSE:     cfg_r.speed_reverse     <= $signed(cfg_data[7:0]);
        ppsc_pkg::REG_STOP_TICKS:        cfg_r.stop_ticks        <= cfg_data[5:0];
      endcase
    end
  end

  // Input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // Capture request payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_path_r  <= in_tdata[PATH_WIDTH-1:0];
      s1_side_r  <= $signed(in_tdata[PATH_WIDTH+RW-1:PATH_WIDTH]);
      s1_rear_r  <= $signed(in_tdata[PATH_WIDTH+2*RW-1:PATH_WIDTH+RW]);
      s1_front_r <= $signed(in_tdata[PATH_WIDTH+3*RW-1:PATH_WIDTH+2*RW]);
    end
  end

  ppsc_step #(
    .PATH_WIDTH(PATH_WIDTH)
  ) u_step (
    .cfg            (cfg_r),
    .state_cur      (state_r),
    .start_path_cur (start_path_r),
    .path           (s1_path_r),
    .side           (s1_side_r),
    .rear           (s1_rear_r),
    .front          (s1_front_r),
    .state_nxt      (state_nxt),
    .start_path_nxt (start_path_nxt),
    .parked         (parked_nxt)
  );

  // Advance sequencer state on each tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ppsc_pkg::STATE_RESET;
      start_path_r <= '0;
    end else if (s1_fire) begin
      state_r      <= state_nxt;
      start_path_r <= start_path_nxt;
    end
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_state_r  <= state_nxt;
      out_parked_r <= parked_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_state_r.phase, out_state_r.steer, out_state_r.speed};
  assign out_tuser  = out_parked_r;

endmodule

### hdl/ppsc_checker.sv
module ppsc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [ppsc_pkg::OUT_DATA_W-1:0]    out_tdata,
  input logic                               out_tuser
);

  logic [3:0] phase;
  logic [7:0] speed;
  logic [9:0] steer;

  assign speed = out_tdata[7:0];
  assign steer = out_tdata[17:8];
  assign phase = out_tdata[21:18];

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Parked only reported from the stop phase
  a_parked_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> phase == ppsc_pkg::PH_STOP)
    else $error("parked outside stop phase");

  // Car stands still in stop phase, and in position phase with the positioning angle
  a_stop_still: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (phase == ppsc_pkg::PH_STOP || phase == ppsc_pkg::PH_POSITION)
    |-> speed == ppsc_pkg::SPEED_ZERO)
    else $error("moving while stopped or positioning");

  a_position_steer: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && phase == ppsc_pkg::PH_POSITION |-> steer == ppsc_pkg::STEER_POSITION)
    else $error("wrong steering in position phase");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind parallel_parking_sequencer_core ppsc_checker u_ppsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned PATH_W          = 32;
  localparam int unsigned IN_W            = ((PATH_W + 48 + 7) / 8) * 8;
  localparam int          WATCHDOG_LIMIT  = 5000;
  localparam int          HOLD_OFF_CYCLES = 60;
  localparam int          MAX_REPORTS     = 100;

  // Steering angles in hundredths
  localparam logic signed [9:0] ANGLE_NEUTRAL    = 10'sd0;
  localparam logic signed [9:0] ANGLE_POSITION   = -10'sd30;
  localparam logic signed [9:0] ANGLE_REVERSE    = 10'sd400;
  localparam logic signed [9:0] ANGLE_BACK_ENTRY = -10'sd500;
  localparam logic signed [9:0] ANGLE_BACK_DRIVE = -10'sd300;

  // One control tick, path in the lowest bits
  typedef struct packed {
    logic signed [15:0] front;
    logic signed [15:0] rear;
    logic signed [15:0] side;
    logic [31:0]        path;
  } tick_t;

  typedef struct {
    logic signed [7:0]  speed;
    logic signed [9:0]  steer;
    ppsc_pkg::phase_t   phase;
    logic               parked;
  } cmd_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [ppsc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic              out_tuser;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [2:0]        cfg_index;
  logic [ppsc_pkg::CFG_DATA_W-1:0] cfg_data;

  // Sequencer shadow: configuration and state
  ppsc_pkg::cfg_t    cfg_sh;
  ppsc_pkg::phase_t  ph_q;
  logic signed [15:0] prev_side_q;
  logic [31:0]       mark_q;
  logic [5:0]        brake_q;
  logic signed [7:0] speed_q;
  logic signed [9:0] steer_q;

  cmd_t exp_cmds[$];
  logic [31:0] path_now;
  int fail_cnt      = 0;
  int snd_idle_pct  = 0;
  int rcv_stall_pct = 0;
  bit hold_off_req  = 1'b0;

  parallel_parking_sequencer_core #(
    .PATH_WIDTH(PATH_W)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin : clock_gen
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Sequencer prediction
  // ---------------------------------------------------------------------

  // Count one brake-wait tick; report and clear when the wait is over
  function automatic logic brake_wait_done();
    if (brake_q != 6'd63) brake_q = brake_q + 6'd1;
    if (brake_q > cfg_sh.stop_ticks) begin
      brake_q = 6'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic cmd_t step_sequencer(input tick_t t);
    cmd_t r;
    logic [31:0] path_delta;
    int prev_i, side_i, rear_i, front_i, bb, fb;
    prev_i  = prev_side_q;
    side_i  = $signed(t.side);
    rear_i  = $signed(t.rear);
    front_i = $signed(t.front);
    bb      = cfg_sh.brake_buffer;
    fb      = cfg_sh.park_margin;
    path_delta = t.path - mark_q;
    prev_side_q = t.side;
    r.parked = 1'b0;
    case (ph_q)
      ppsc_pkg::PH_INITIAL: begin
        speed_q = cfg_sh.speed_forward;
        steer_q = ANGLE_NEUTRAL;
        if (side_i > 0 && prev_i > 0) ph_q = ppsc_pkg::PH_SEARCH;
      end
      ppsc_pkg::PH_SEARCH: begin
        speed_q = cfg_sh.speed_forward;
        if (side_i < 0 && prev_i < 0) begin
          mark_q = t.path;
          ph_q   = ppsc_pkg::PH_MEASURE;
        end
      end
      ppsc_pkg::PH_MEASURE: begin
        if (side_i > 0 && prev_i > 0) begin
          if (path_delta > {16'd0, cfg_sh.min_gap}) begin
            speed_q = 8'sd0;
            steer_q = ANGLE_POSITION;
            ph_q    = ppsc_pkg::PH_POSITION;
          end else begin
            ph_q = ppsc_pkg::PH_SEARCH;
          end
        end
      end
      ppsc_pkg::PH_POSITION: begin
        if (brake_wait_done()) begin
          speed_q = cfg_sh.speed_reverse;
          steer_q = ANGLE_REVERSE;
          mark_q  = t.path;
          ph_q    = ppsc_pkg::PH_REVERSE;
        end
      end
      ppsc_pkg::PH_REVERSE: begin
        if (path_delta > {16'd0, cfg_sh.reverse_length}) begin
          steer_q = ANGLE_BACK_ENTRY;
          mark_q  = t.path;
          ph_q    = ppsc_pkg::PH_BACK;
        end
      end
      ppsc_pkg::PH_BACK: begin
        speed_q = cfg_sh.speed_reverse;
        steer_q = ANGLE_BACK_DRIVE;
        if (path_delta > {16'd0, cfg_sh.straighten_length}) begin
          speed_q = 8'sd0;
          steer_q = ANGLE_NEUTRAL;
          ph_q    = ppsc_pkg::PH_FRONT;
        end else if (rear_i >= 0 && rear_i <= bb) begin
          speed_q = 8'sd0;
          if (brake_wait_done()) ph_q = ppsc_pkg::PH_FRONT;
        end
      end
      ppsc_pkg::PH_FRONT: begin
        if (front_i >= 0 && front_i <= bb) begin
          speed_q = 8'sd0;
          if (brake_wait_done()) ph_q = ppsc_pkg::PH_FINISH;
        end
      end
      ppsc_pkg::PH_FINISH: begin
        if (rear_i > 0 && rear_i <= fb) begin
          speed_q = cfg_sh.speed_forward;
        end else if (front_i > 0 && front_i <= fb) begin
          speed_q = cfg_sh.speed_reverse;
        end else begin
          speed_q = 8'sd0;
          ph_q    = ppsc_pkg::PH_STOP;
        end
      end
      ppsc_pkg::PH_STOP: begin
        speed_q = 8'sd0;
        if (brake_wait_done()) r.parked = 1'b1;
      end
      default: ;
    endcase
    r.speed = speed_q;
    r.steer = steer_q;
    r.phase = ph_q;
    return r;
  endfunction

  // Mirror one register write, masked to the register width
  function automatic void apply_reg(input ppsc_pkg::reg_idx_t idx, input logic [15:0] d);
    case (idx)
      ppsc_pkg::REG_MIN_GAP:           cfg_sh.min_gap           = d;
      ppsc_pkg::REG_REVERSE_LENGTH:    cfg_sh.reverse_length    = d;
      ppsc_pkg::REG_STRAIGHTEN_LENGTH: cfg_sh.straighten_length = d;
      ppsc_pkg::REG_BRAKE_BUFFER:      cfg_sh.brake_buffer      = d[14:0];
      ppsc_pkg::REG_PARK_MARGIN:       cfg_sh.park_margin       = d[14:0];
      ppsc_pkg::REG_SPEED_FORWARD:     cfg_sh.speed_forward     = d[7:0];
      ppsc_pkg::REG_SPEED_REVERSE:     cfg_sh.speed_reverse     = d[7:0];
      ppsc_pkg::REG_STOP_TICKS:        cfg_sh.stop_ticks        = d[5:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic logic signed [15:0] any_range();
    logic [31:0] v;
    v = $urandom();
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] pos_range();
    int v;
    if ($urandom_range(1) == 0) v = $urandom_range(1000, 1);
    else v = $urandom_range(32767, 1);
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] neg_range();
    int v;
    v = 0 - int'($urandom_range(32768, 1));
    return v[15:0];
  endfunction

  // Pick a range in [lo, hi], edges included often
  function automatic logic signed [15:0] in_window(input int lo, input int hi);
    int v;
    case ($urandom_range(3))
      0: v = lo;
      1: v = hi;
      default: v = $urandom_range(hi, lo);
    endcase
    return v[15:0];
  endfunction

  function automatic tick_t mk(input logic [31:0] p, input int s, input int r, input int f);
    tick_t t;
    t.path  = p;
    t.side  = s[15:0];
    t.rear  = r[15:0];
    t.front = f[15:0];
    return t;
  endfunction

  // Build the next tick so that it mostly drives the current phase forward
  function automatic tick_t make_tick(input bit allow_deep);
    tick_t t;
    int roll, bb, fb;
    logic [31:0] path_delta;
    bb   = cfg_sh.brake_buffer;
    fb   = cfg_sh.park_margin;
    roll = $urandom_range(99);
    if (ph_q == ppsc_pkg::PH_REVERSE || ph_q == ppsc_pkg::PH_BACK)
      path_now = path_now + $urandom_range(80);
    else path_now = path_now + $urandom_range(300);
    t.path  = path_now;
    t.side  = any_range();
    t.rear  = any_range();
    t.front = any_range();
    if (roll < 6 && ph_q != ppsc_pkg::PH_REVERSE && ph_q != ppsc_pkg::PH_BACK) begin
      t.path   = $urandom();
      path_now = t.path;
    end else if (roll >= 15) begin
      case (ph_q)
        ppsc_pkg::PH_INITIAL: if ($urandom_range(99) < 70) t.side = pos_range();
        ppsc_pkg::PH_SEARCH:  if ($urandom_range(99) < 65) t.side = neg_range();
        ppsc_pkg::PH_MEASURE: begin
          roll = $urandom_range(99);
          if (roll < 45) t.side = pos_range();
          else if (roll < 85) t.side = neg_range();
          else t.side = 16'sd0;
        end
        ppsc_pkg::PH_BACK: begin
          if ($urandom_range(99) < 55) t.rear = in_window(0, bb);
          else if ($urandom_range(99) < 15) t.rear = 16'(bb + 1);
        end
        ppsc_pkg::PH_FRONT: begin
          if ($urandom_range(99) < 55) t.front = in_window(0, bb);
          else if ($urandom_range(99) < 15) t.front = 16'(bb + 1);
        end
        ppsc_pkg::PH_FINISH: begin
          roll = $urandom_range(99);
          if (roll < 35) begin
            t.rear = in_window(1, fb);
          end else if (roll < 65) begin
            t.rear  = neg_range();
            t.front = in_window(1, fb);
          end
        end
        default: ;
      endcase
    end
    // Keep out of the one-way part of the sequence unless allowed
    if (!allow_deep && ph_q == ppsc_pkg::PH_MEASURE && $signed(t.side) > 0 &&
        prev_side_q > 0) begin
      path_delta = t.path - mark_q;
      if (path_delta > {16'd0, cfg_sh.min_gap}) t.side = neg_range();
    end
    return t;
  endfunction

  function automatic ppsc_pkg::cfg_t rand_cfg(input bit moderate);
    ppsc_pkg::cfg_t c;
    c.speed_forward = 8'($urandom());
    c.speed_reverse = 8'($urandom());
    if (moderate) begin
      c.min_gap           = 16'($urandom_range(800));
      c.reverse_length    = 16'($urandom_range(1500));
      c.straighten_length = 16'($urandom_range(1500));
      c.brake_buffer      = 15'($urandom_range(1000));
      c.park_margin       = 15'($urandom_range(1000));
      c.stop_ticks        = 6'($urandom_range(30));
    end else begin
      c.min_gap           = 16'($urandom());
      c.reverse_length    = 16'($urandom());
      c.straighten_length = 16'($urandom());
      c.brake_buffer      = 15'($urandom());
      c.park_margin       = 15'($urandom());
      c.stop_ticks        = 6'($urandom_range(62));
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Offer one request, predict its result once taken; returns at a falling edge
  task automatic send_tick(input tick_t t);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= t;
    do @(posedge clk); while (!in_tready);
    exp_cmds.push_back(step_sequencer(t));
    @(negedge clk);
  endtask

  task automatic run_ticks(input int n, input bit allow_deep);
    repeat (n) send_tick(make_tick(allow_deep));
  endtask

  // Stop offering and wait for every pending result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (exp_cmds.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all registers while idle; upper data bits carry junk
  task automatic program_regs(input ppsc_pkg::cfg_t c);
    logic [15:0] junk;
    logic [15:0] word [8];
    ppsc_pkg::reg_idx_t idx;
    junk = 16'($urandom());
    word[ppsc_pkg::REG_MIN_GAP]           = c.min_gap;
    word[ppsc_pkg::REG_REVERSE_LENGTH]    = c.reverse_length;
    word[ppsc_pkg::REG_STRAIGHTEN_LENGTH] = c.straighten_length;
    word[ppsc_pkg::REG_BRAKE_BUFFER]      = {junk[15], c.brake_buffer};
    word[ppsc_pkg::REG_PARK_MARGIN]       = {junk[14], c.park_margin};
    word[ppsc_pkg::REG_SPEED_FORWARD]     = {junk[15:8], c.speed_forward};
    word[ppsc_pkg::REG_SPEED_REVERSE]     = {junk[7:0], c.speed_reverse};
    word[ppsc_pkg::REG_STOP_TICKS]        = {junk[15:6], c.stop_ticks};
    drain_results();
    idx = ppsc_pkg::REG_MIN_GAP;
    repeat (idx.num()) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= word[idx];
      do @(posedge clk); while (!cfg_ready);
      apply_reg(idx, word[idx]);
      idx = idx.next();
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stalls, or one long hold-off on request
  initial begin : receiver
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  // Compare each result with the oldest predicted command
  always @(posedge clk) begin : result_check
    cmd_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_cmds.size() == 0) begin
        fail_cnt++;
        $display("%0t: result with no pending request: tdata %h tuser %b",
                 $time, out_tdata, out_tuser);
      end else begin
        want = exp_cmds.pop_front();
        if (out_tdata[7:0] !== want.speed || out_tdata[17:8] !== want.steer ||
            out_tdata[21:18] !== want.phase || out_tdata[23:22] !== 2'b00 ||
            out_tuser !== want.parked) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("%0t: mismatch: expected speed %0d steer %0d phase %0d parked %0b,",
                     $time, want.speed, want.steer, want.phase, want.parked,
                     " got speed %0d steer %0d phase %0d parked %0b pad %b",
                     $signed(out_tdata[7:0]), $signed(out_tdata[17:8]),
                     out_tdata[21:18], out_tuser, out_tdata[23:22]);
        end
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("parallel_parking_sequencer_core regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  task automatic init_shadow();
    cfg_sh.min_gap           = 16'd650;
    cfg_sh.reverse_length    = 16'd600;
    cfg_sh.straighten_length = 16'd500;
    cfg_sh.brake_buffer      = 15'd220;
    cfg_sh.park_margin       = 15'd300;
    cfg_sh.speed_forward     = 8'sd2;
    cfg_sh.speed_reverse     = 8'sd1;
    cfg_sh.stop_ticks        = 6'd20;
    ph_q        = ppsc_pkg::PH_INITIAL;
    prev_side_q = 16'sd0;
    mark_q      = 32'd0;
    brake_q     = 6'd0;
    speed_q     = 8'sd0;
    steer_q     = 10'sd0;
    path_now    = 32'd0;
  endtask

  // Range extremes, zero side, path wrap and gap equal to the limit
  task automatic test_directed_early();
    send_tick(mk(32'h0000_0000, 0, 0, 0));
    send_tick(mk(32'hFFFF_FFFF, 32767, 32767, 32767));
    send_tick(mk(32'h0000_0064, 1, -32768, -32768));
    send_tick(mk(32'h0000_00C8, -32768, -1, -1));
    send_tick(mk(32'h0000_012C, 0, 1, 1));
    send_tick(mk(32'h0000_0190, -1, 220, 220));
    send_tick(mk(32'hFFFF_FF80, -1, 221, 221));
    send_tick(mk(32'hFFFF_FFF0, 5, 300, 300));
    send_tick(mk(32'hFFFF_FFFF, 0, 301, 301));
    send_tick(mk(32'h0000_0200, 7, 0, -32768));
    // gap exactly at the limit falls back to search
    send_tick(mk(32'h0000_020A, 7, -32768, 0));
    send_tick(mk(32'h0000_030A, -2, 32767, -1));
    send_tick(mk(32'h0000_040A, -3, -1, 32767));
    send_tick(mk(32'h0000_050A, 32767, 0, 0));
    send_tick(mk(32'h0000_050A, -32768, 0, 0));
    send_tick(mk(32'h0000_060A, 1, 0, 0));
    send_tick(mk(32'h0000_068B, 1, 0, 0));
    send_tick(mk(32'h0000_0700, -1, 0, 0));
    send_tick(mk(32'h0000_0701, -1, 0, 0));
    send_tick(mk(32'h0000_0701, 1, 0, 0));
    send_tick(mk(32'h0000_0701, 1, 0, 0));
    path_now = 32'h0000_0701;
  endtask

  task automatic test_register_extremes();
    ppsc_pkg::cfg_t c;
    c = '{min_gap: 16'd0, reverse_length: 16'd0, straighten_length: 16'd0,
          brake_buffer: 15'd0, park_margin: 15'd0, speed_forward: 8'h80,
          speed_reverse: 8'h7F, stop_ticks: 6'd0};
    program_regs(c);
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    run_ticks(130, 1'b0);
    c = '{min_gap: 16'hFFFF, reverse_length: 16'hFFFF, straighten_length: 16'hFFFF,
          brake_buffer: 15'h7FFF, park_margin: 15'h7FFF, speed_forward: 8'h7F,
          speed_reverse: 8'h80, stop_ticks: 6'd62};
    program_regs(c);
    snd_idle_pct = 55;
    run_ticks(130, 1'b0);
  endtask

  task automatic test_receiver_stall();
    program_regs(rand_cfg(1'b0));
    snd_idle_pct  = 0;
    rcv_stall_pct = 55;
    run_ticks(130, 1'b0);
  endtask

  // Let the sequence run into positioning, reversing and straightening
  task automatic test_park_sequence();
    program_regs(rand_cfg(1'b1));
    snd_idle_pct  = 18;
    rcv_stall_pct = 18;
    run_ticks(220, 1'b1);
  endtask

  // Hold the result side off long enough to fill the pipeline
  task automatic test_backpressure();
    program_regs(rand_cfg(1'b1));
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_off_req  = 1'b1;
    run_ticks(150, 1'b1);
  endtask

  // Saturated brake counter, then a wait that completes on every tick
  task automatic test_stop_counter();
    ppsc_pkg::cfg_t c;
    c = rand_cfg(1'b1);
    c.stop_ticks = 6'd63;
    program_regs(c);
    snd_idle_pct  = 55;
    rcv_stall_pct = 0;
    run_ticks(80, 1'b1);
    c.stop_ticks = 6'd0;
    program_regs(c);
    run_ticks(80, 1'b1);
  endtask

  task automatic finish_run();
    drain_results();
    repeat (8) @(negedge clk);
    if (fail_cnt == 0)
      $display("parallel_parking_sequencer_core regression: pass");
    else
      $display("parallel_parking_sequencer_core regression: fail");
    $finish;
  endtask

  initial begin : stimulus
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = 3'd0;
    cfg_data  = '0;
    init_shadow();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_early();
    test_register_extremes();
    test_receiver_stall();
    test_park_sequence();
    test_backpressure();
    test_stop_counter();
    finish_run();
  end

endmodule

### sim.f
hdl/ppsc_pkg.sv
hdl/ppsc_step.sv
hdl/parallel_parking_sequencer_core.sv
hdl/ppsc_checker.sv
verif/tb_top.sv
